/* hdl/integer_to_roman_numeral_assert.svh */
// Assertion macros used by the integer to Roman numeral converter datapath.
`ifndef INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define ITR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ITR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/itr_pkg.sv */
// Shared types, constants and pattern functions of the Roman numeral converter.
package itr_pkg;

  localparam int ValueW     = 14;
  localparam int DigitW     = 4;
  localparam int DigitCount = 4;
  localparam int SymbolW    = 3;
  localparam int RecipW     = 16;
  localparam int RecipShift = 19;
  localparam int ProdW      = ValueW + RecipW;
  localparam int QuotW      = ProdW - RecipShift;

  // floor(v / 10) == (v * RecipTen) >> RecipShift for every 14-bit v.
  localparam logic [RecipW-1:0] RecipTen = 16'd52429;

  localparam logic [DigitW-1:0] ThousandsMax = 4'd3;

  // Symbol codes relative to the base of a decimal position.
  localparam logic [1:0] CodeOne  = 2'd0;
  localparam logic [1:0] CodeFive = 2'd1;
  localparam logic [1:0] CodeTen  = 2'd2;

  typedef logic [1:0]         pos_t;
  typedef logic [2:0]         step_t;
  typedef logic [DigitW-1:0]  digit_t;
  typedef logic [SymbolW-1:0] symbol_t;

  typedef struct packed {
    logic load;
    logic extract;
    logic skip;
    logic emit_sym;
    logic emit_empty;
  } itr_cmd_t;

  typedef struct packed {
    logic extract_last;
    logic rest_empty;
    logic cur_empty;
    logic sym_last;
    logic out_free;
  } itr_status_t;

  // Number of symbols that a decimal digit produces.
  function automatic step_t pattern_len(input digit_t d);
    step_t len;
    unique case (d)
      4'd1, 4'd5:             len = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: len = 3'd2;
      4'd3, 4'd7:             len = 3'd3;
      4'd8:                   len = 3'd4;
      default:                len = 3'd0;
    endcase
    return len;
  endfunction

  // Relative symbol code at a given step of a digit's pattern.
  function automatic logic [1:0] pattern_code(input digit_t d, input logic [1:0] step);
    logic [1:0] code;
    priority if (d == 4'd4) begin
      code = (step == 2'd0) ? CodeOne : CodeFive;
    end else if (d == 4'd9) begin
      code = (step == 2'd0) ? CodeOne : CodeTen;
    end else if (d >= 4'd5 && d <= 4'd8) begin
      code = (step == 2'd0) ? CodeFive : CodeOne;
    end else begin
      code = CodeOne;
    end
    return code;
  endfunction

endpackage

/* hdl/itr_datapath.sv */
// Datapath: digit extraction, digit store, symbol counters and result register.
`include "integer_to_roman_numeral_assert.svh"

module itr_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [itr_pkg::ValueW-1:0]   value,
  input  itr_pkg::itr_cmd_t            cmd,
  output itr_pkg::itr_status_t         st,
  input  logic                         rsp_stall,
  output logic                         rsp_valid,
  output logic [itr_pkg::SymbolW-1:0]  symbol,
  output logic                         symbol_valid,
  output logic                         last
);
  import itr_pkg::*;

  logic [ValueW-1:0] work;
  digit_t            digits [DigitCount];
  pos_t              pos;
  step_t             step;
  logic              rsp_valid_r;
  symbol_t           symbol_r;
  logic              symbol_valid_r;
  logic              last_r;

  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot;
  logic [ValueW-1:0] tens;
  digit_t            rem;
  digit_t            eff [DigitCount];
  digit_t            cur_d;
  step_t             cur_len;
  step_t             step_inc;
  logic [1:0]        code;
  symbol_t           symbol_next;
  logic              lower_zero;
  logic              rest_zero;
  logic              out_free;

  // Divide by ten through a reciprocal; the remainder is the next digit.
  always_comb begin
    prod = ProdW'(work) * ProdW'(RecipTen);
    quot = prod[ProdW-1:RecipShift];
    tens = ValueW'({quot, 3'b000}) + ValueW'({quot, 1'b0});
    rem  = DigitW'(work - tens);
  end

  // A thousands digit above three produces nothing and counts as zero.
  always_comb begin
    for (int p = 0; p < DigitCount; p++) begin
      if (p == DigitCount - 1 && digits[p] > ThousandsMax) begin
        eff[p] = '0;
      end else begin
        eff[p] = digits[p];
      end
    end
  end

  always_comb begin
    lower_zero = 1'b1;
    rest_zero  = 1'b1;
    for (int p = 0; p < DigitCount; p++) begin
      if (pos_t'(p) < pos && eff[p] != '0) begin
        lower_zero = 1'b0;
      end
      if (pos_t'(p) <= pos && eff[p] != '0) begin
        rest_zero = 1'b0;
      end
    end
  end

  always_comb begin
    cur_d       = eff[pos];
    cur_len     = pattern_len(cur_d);
    step_inc    = step + 3'd1;
    code        = pattern_code(cur_d, step[1:0]);
    symbol_next = {pos, 1'b0} + {1'b0, code};
    out_free    = !rsp_valid_r || !rsp_stall;
  end

  assign st.extract_last = (pos == pos_t'(DigitCount - 1));
  assign st.rest_empty   = rest_zero;
  assign st.cur_empty    = (cur_len == '0);
  assign st.sym_last     = (step_inc == cur_len) && lower_zero;
  assign st.out_free     = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      step        <= '0;
      rsp_valid_r <= 1'b0;
      for (int p = 0; p < DigitCount; p++) begin
        digits[p] <= '0;
      end
    end else begin
      if (cmd.load) begin
        pos  <= '0;
        step <= '0;
      end
      if (cmd.extract) begin
        digits[pos] <= rem;
        if (pos != pos_t'(DigitCount - 1)) begin
          pos <= pos + 2'd1;
        end
      end
      if (cmd.skip) begin
        pos  <= pos - 2'd1;
        step <= '0;
      end
      if (cmd.emit_sym) begin
        if (st.sym_last) begin
          pos  <= '0;
          step <= '0;
        end else if (step_inc == cur_len) begin
          pos  <= pos - 2'd1;
          step <= '0;
        end else begin
          step <= step_inc;
        end
      end
      if (cmd.emit_empty) begin
        pos  <= '0;
        step <= '0;
      end
      rsp_valid_r <= (rsp_valid_r && rsp_stall) || cmd.emit_sym || cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= value;
    end else if (cmd.extract) begin
      work <= ValueW'(quot);
    end
    if (cmd.emit_sym) begin
      symbol_r       <= symbol_next;
      symbol_valid_r <= 1'b1;
      last_r         <= st.sym_last;
    end else if (cmd.emit_empty) begin
      symbol_r       <= '0;
      symbol_valid_r <= 1'b0;
      last_r         <= 1'b1;
    end
  end

  assign rsp_valid    = rsp_valid_r;
  assign symbol       = symbol_r;
  assign symbol_valid = symbol_valid_r;
  assign last         = last_r;

  `ITR_ASSERT_IMPLY(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command at once")
  `ITR_ASSERT_IMPLY(a_no_overwrite, cmd.emit_sym || cmd.emit_empty, out_free, "result overwritten before transfer")
  `ITR_ASSERT_NEXT(a_run_end, cmd.emit_sym && st.sym_last, pos == '0 && step == '0, "counters not cleared after run")
  `ITR_ASSERT_IMPLY(a_empty_last, rsp_valid_r && !symbol_valid_r, last_r, "empty result not marked last")
  `ITR_ASSERT_IMPLY(a_sym_range, rsp_valid_r, symbol_r != 3'd7, "symbol code out of range")

endmodule

/* hdl/itr_ctrl.sv */
// Controller state machine: sequences extraction and symbol emission.
module itr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  itr_pkg::itr_status_t st,
  output itr_pkg::itr_cmd_t    cmd
);
  import itr_pkg::*;

  typedef enum logic [2:0] {
    IDLE    = 3'b001,
    EXTRACT = 3'b010,
    EMIT    = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = EXTRACT;
        end
      end
      EXTRACT: begin
        cmd.extract = 1'b1;
        if (st.extract_last) begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        // Digits without symbols are stepped over without producing a result.
        priority if (st.rest_empty) begin
          if (st.out_free) begin
            cmd.emit_empty = 1'b1;
            state_next     = IDLE;
          end
        end else if (st.cur_empty) begin
          cmd.skip = 1'b1;
        end else if (st.out_free) begin
          cmd.emit_sym = 1'b1;
          if (st.sym_last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/integer_to_roman_numeral.sv */
// Integer to Roman numeral converter: one value in, a run of symbols out.
// Each value is loaded, split into decimal digits by repeated division by ten, then
// emitted one symbol at a time; symbol-free digits ahead of the last symbol are stepped
// over, and a held result blocks emission. The next value is taken once the last result
// is loaded. Synchronous reset clears the control state, counters, digits and valid flag.
module integer_to_roman_numeral (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [itr_pkg::ValueW-1:0]   value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [itr_pkg::SymbolW-1:0]  symbol,
  output logic                         symbol_valid,
  output logic                         last
);
  import itr_pkg::*;

  itr_cmd_t    cmd;
  itr_status_t st;

  itr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  itr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .st           (st),
    .rsp_stall    (rsp_stall),
    .rsp_valid    (rsp_valid),
    .symbol       (symbol),
    .symbol_valid (symbol_valid),
    .last         (last)
  );

endmodule
